// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define RICV_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Property checked on every rising clock edge, reset included.
`define RICV_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

// ----- hdl/ricv_pkg.sv -----
// Shared types and constants of the RGB image compare verdict block.
package ricv_pkg;

    localparam int PIXEL_COUNT_BITS_DEFAULT = 24;

    localparam int CHAN_W     = 8;
    localparam int SUM_W      = 34;
    localparam int OVER_W     = 24;
    localparam int MEAN_TOL_W = 16;
    localparam int MAX_TOL_W  = 8;
    localparam int FRAC_TOL_W = 17;
    localparam int PIX_TOL_W  = 8;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;

    // Fixed-point scales of the tolerance registers.
    localparam int MEAN_SCALE_SHIFT = 8;
    localparam int FRAC_SCALE_SHIFT = 16;

    // Amplified difference pixel.
    localparam logic [CHAN_W-1:0] AMP_KNEE = 8'd25;
    localparam logic [CHAN_W-1:0] AMP_GAIN = 8'd10;
    localparam logic [CHAN_W-1:0] AMP_SAT  = 8'd255;

    localparam logic [MEAN_TOL_W-1:0] MEAN_TOL_RESET = 16'd128;
    localparam logic [MAX_TOL_W-1:0]  MAX_TOL_RESET  = 8'd40;
    localparam logic [FRAC_TOL_W-1:0] FRAC_TOL_RESET = 17'd131;
    localparam logic [PIX_TOL_W-1:0]  PIX_TOL_RESET  = 8'd12;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MEAN_TOL = 2'd0,
        REG_MAX_TOL  = 2'd1,
        REG_FRAC_TOL = 2'd2,
        REG_PIX_TOL  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [MEAN_TOL_W-1:0] mean_tol_q8;
        logic [MAX_TOL_W-1:0]  max_tol;
        logic [FRAC_TOL_W-1:0] frac_tol_q16;
        logic [PIX_TOL_W-1:0]  pix_tol;
    } cfg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] golden_red;
        logic [CHAN_W-1:0] golden_green;
        logic [CHAN_W-1:0] golden_blue;
        logic [CHAN_W-1:0] cand_red;
        logic [CHAN_W-1:0] cand_green;
        logic [CHAN_W-1:0] cand_blue;
        logic              frame_end;
    } pixel_req_t;

    typedef struct packed {
        logic [CHAN_W-1:0] diff_red;
        logic [CHAN_W-1:0] diff_green_blue;
        logic              frame_end;
    } pixel_result_t;

endpackage

// ----- hdl/rgb_image_compare_verdict.sv -----
// Top level of the RGB image compare verdict block.
//
// Each request carries one golden and one candidate RGB8 pixel and yields
// one result: an amplified difference pixel (ten times the largest channel
// difference, 255 above 25, green and blue forced to zero when the pixel is
// over the pixel tolerance). The request flagged with s_tlast closes a
// frame; its result comes out with m_tlast high and carries the frame
// totals (largest channel difference, count of bad pixels saturated to
// 24 bits, sum of all channel differences) and the pass verdict on m_tuser,
// after which the totals restart from zero. The block takes one request per
// clock cycle and keeps doing so for as long as the result side takes its
// results. A request goes through four register stages: the input
// register, the accumulator stage, the product stage where the mean and
// fraction budgets are multiplied by the pixel count, and the result
// register. The input register takes the request at the accepting edge, and
// its result then passes the accumulator, product and result registers to
// reach m_tvalid; the two multiplications set that depth. There is
// no start-up sweep: the block takes requests right after reset. Tolerance
// registers are written through cfg_wr_en, cfg_index and cfg_wdata, and
// may only change while no request is in flight. The pixel and bad-pixel
// counters are PIXEL_COUNT_BITS wide and saturate, as does the 34-bit sum.
module rgb_image_compare_verdict #(
    parameter int PIXEL_COUNT_BITS = ricv_pkg::PIXEL_COUNT_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // golden_red, golden_green, golden_blue, cand_red, cand_green, cand_blue
    input  logic [47:0]                         s_tdata,
    input  logic                                s_tlast,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // diff_red, diff_green_blue, max_channel_diff, over_count, diff_sum, zero pad
    output logic [87:0]                         m_tdata,
    // pass_flag
    output logic                                m_tuser,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_wr_en,
    input  logic [ricv_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ricv_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int CW = ricv_pkg::CHAN_W;

    ricv_pkg::cfg_t              cfg_reg;
    logic                        in_valid_reg;
    ricv_pkg::pixel_req_t        in_req_reg;
    ricv_pkg::pixel_req_t        in_req_next;

    logic                        px_in_ready;
    logic                        px_out_valid;
    logic                        vd_in_ready;
    ricv_pkg::pixel_result_t     px_result;
    logic [ricv_pkg::SUM_W-1:0]  tot_sum;
    logic [CW-1:0]               tot_max;
    logic [PIXEL_COUNT_BITS-1:0] tot_bad;
    logic [PIXEL_COUNT_BITS-1:0] tot_count;

    logic [CW-1:0]               diff_red;
    logic [CW-1:0]               diff_green_blue;
    logic [CW-1:0]               max_channel_diff;
    logic [ricv_pkg::OVER_W-1:0] over_count;
    logic [ricv_pkg::SUM_W-1:0]  diff_sum;
    logic                        in_load;

    // Configuration registers; an index outside the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mean_tol_q8  <= ricv_pkg::MEAN_TOL_RESET;
            cfg_reg.max_tol      <= ricv_pkg::MAX_TOL_RESET;
            cfg_reg.frac_tol_q16 <= ricv_pkg::FRAC_TOL_RESET;
            cfg_reg.pix_tol      <= ricv_pkg::PIX_TOL_RESET;
        end else if (cfg_wr_en) begin
            case (ricv_pkg::cfg_reg_t'(cfg_index))
                ricv_pkg::REG_MEAN_TOL: begin
                    cfg_reg.mean_tol_q8 <= cfg_wdata[ricv_pkg::MEAN_TOL_W-1:0];
                end
                ricv_pkg::REG_MAX_TOL: begin
                    cfg_reg.max_tol <= cfg_wdata[ricv_pkg::MAX_TOL_W-1:0];
                end
                ricv_pkg::REG_FRAC_TOL: begin
                    cfg_reg.frac_tol_q16 <= cfg_wdata[ricv_pkg::FRAC_TOL_W-1:0];
                end
                ricv_pkg::REG_PIX_TOL: begin
                    cfg_reg.pix_tol <= cfg_wdata[ricv_pkg::PIX_TOL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The input register unpacks the request; it refills whenever the
    // accumulator stage takes its content.
    assign in_load  = !in_valid_reg || px_in_ready;
    assign s_tready = in_load;

    always_comb begin
        in_req_next.golden_red   = s_tdata[7:0];
        in_req_next.golden_green = s_tdata[15:8];
        in_req_next.golden_blue  = s_tdata[23:16];
        in_req_next.cand_red     = s_tdata[31:24];
        in_req_next.cand_green   = s_tdata[39:32];
        in_req_next.cand_blue    = s_tdata[47:40];
        in_req_next.frame_end    = s_tlast;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_load) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_req_reg <= in_req_next;
        end
    end

    ricv_pixel_stage #(
        .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
    ) u_pixel (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (in_valid_reg),
        .in_ready   (px_in_ready),
        .in_req     (in_req_reg),
        .pix_tol    (cfg_reg.pix_tol),
        .out_valid  (px_out_valid),
        .out_ready  (vd_in_ready),
        .out_result (px_result),
        .tot_sum    (tot_sum),
        .tot_max    (tot_max),
        .tot_bad    (tot_bad),
        .tot_count  (tot_count)
    );

    ricv_verdict_stage #(
        .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
    ) u_verdict (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (px_out_valid),
        .in_ready         (vd_in_ready),
        .in_result        (px_result),
        .tot_sum          (tot_sum),
        .tot_max          (tot_max),
        .tot_bad          (tot_bad),
        .tot_count        (tot_count),
        .cfg              (cfg_reg),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .diff_red         (diff_red),
        .diff_green_blue  (diff_green_blue),
        .verdict_valid    (m_tlast),
        .pass_flag        (m_tuser),
        .max_channel_diff (max_channel_diff),
        .over_count       (over_count),
        .diff_sum         (diff_sum)
    );

    // Result fields are packed from the lowest bit up, padded to whole bytes.
    assign m_tdata = {6'd0, diff_sum, over_count, max_channel_diff,
                      diff_green_blue, diff_red};

endmodule

// ----- hdl/ricv_pixel_stage.sv -----
// Per-pixel differences, amplified diff pixel and the frame accumulators.
module ricv_pixel_stage #(
    parameter int PIXEL_COUNT_BITS = ricv_pkg::PIXEL_COUNT_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  ricv_pkg::pixel_req_t              in_req,
    input  logic [ricv_pkg::PIX_TOL_W-1:0]    pix_tol,
    output logic                              out_valid,
    input  logic                              out_ready,
    output ricv_pkg::pixel_result_t           out_result,
    output logic [ricv_pkg::SUM_W-1:0]        tot_sum,
    output logic [ricv_pkg::CHAN_W-1:0]       tot_max,
    output logic [PIXEL_COUNT_BITS-1:0]       tot_bad,
    output logic [PIXEL_COUNT_BITS-1:0]       tot_count
);

    localparam int CW = ricv_pkg::CHAN_W;
    localparam int SW = ricv_pkg::SUM_W;
    // Sum of three channel differences needs two more bits than a channel.
    localparam int TRIPLE_W = CW + 2;

    function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a,
                                               input logic [CW-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    logic                        valid_reg;
    ricv_pkg::pixel_result_t     result_reg;
    ricv_pkg::pixel_result_t     result_next;
    logic [SW-1:0]               sum_acc_reg,   sum_acc_next;
    logic [CW-1:0]               max_acc_reg,   max_acc_next;
    logic [PIXEL_COUNT_BITS-1:0] bad_acc_reg,   bad_acc_next;
    logic [PIXEL_COUNT_BITS-1:0] count_acc_reg, count_acc_next;
    logic [SW-1:0]               tot_sum_reg;
    logic [CW-1:0]               tot_max_reg;
    logic [PIXEL_COUNT_BITS-1:0] tot_bad_reg;
    logic [PIXEL_COUNT_BITS-1:0] tot_count_reg;

    logic [CW-1:0]       diff_r, diff_g, diff_b, worst;
    logic [TRIPLE_W-1:0] triple;
    logic [SW:0]         sum_wide;
    logic                bad;
    logic [CW-1:0]       amp;
    logic                load;
    logic                xfer;

    assign load     = !valid_reg || out_ready;
    assign in_ready = load;
    assign xfer     = in_valid && load;

    always_comb begin
        diff_r = abs_diff(in_req.golden_red,   in_req.cand_red);
        diff_g = abs_diff(in_req.golden_green, in_req.cand_green);
        diff_b = abs_diff(in_req.golden_blue,  in_req.cand_blue);
        worst  = diff_r;
        if (diff_g > worst) begin
            worst = diff_g;
        end
        if (diff_b > worst) begin
            worst = diff_b;
        end
        triple = TRIPLE_W'(diff_r) + TRIPLE_W'(diff_g) + TRIPLE_W'(diff_b);

        // The sum saturates instead of wrapping.
        sum_wide     = {1'b0, sum_acc_reg} + (SW + 1)'(triple);
        sum_acc_next = sum_wide[SW] ? {SW{1'b1}} : sum_wide[SW-1:0];
        max_acc_next = (worst > max_acc_reg) ? worst : max_acc_reg;

        bad          = worst > pix_tol;
        bad_acc_next = (bad && (bad_acc_reg != {PIXEL_COUNT_BITS{1'b1}}))
                       ? bad_acc_reg + 1'b1 : bad_acc_reg;
        count_acc_next = (count_acc_reg != {PIXEL_COUNT_BITS{1'b1}})
                         ? count_acc_reg + 1'b1 : count_acc_reg;

        amp = (worst > ricv_pkg::AMP_KNEE) ? ricv_pkg::AMP_SAT
                                           : CW'(worst * ricv_pkg::AMP_GAIN);
        result_next.diff_red        = amp;
        result_next.diff_green_blue = bad ? '0 : amp;
        result_next.frame_end       = in_req.frame_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            sum_acc_reg   <= '0;
            max_acc_reg   <= '0;
            bad_acc_reg   <= '0;
            count_acc_reg <= '0;
        end else begin
            if (load) begin
                valid_reg <= in_valid;
            end
            if (xfer) begin
                if (in_req.frame_end) begin
                    sum_acc_reg   <= '0;
                    max_acc_reg   <= '0;
                    bad_acc_reg   <= '0;
                    count_acc_reg <= '0;
                end else begin
                    sum_acc_reg   <= sum_acc_next;
                    max_acc_reg   <= max_acc_next;
                    bad_acc_reg   <= bad_acc_next;
                    count_acc_reg <= count_acc_next;
                end
            end
        end
    end

    // Totals including the current pixel travel with it down the pipeline.
    always_ff @(posedge aclk) begin
        if (xfer) begin
            result_reg    <= result_next;
            tot_sum_reg   <= sum_acc_next;
            tot_max_reg   <= max_acc_next;
            tot_bad_reg   <= bad_acc_next;
            tot_count_reg <= count_acc_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;
    assign tot_sum    = tot_sum_reg;
    assign tot_max    = tot_max_reg;
    assign tot_bad    = tot_bad_reg;
    assign tot_count  = tot_count_reg;

endmodule

// ----- hdl/ricv_verdict_stage.sv -----
// Verdict products and comparisons, and the result register.
module ricv_verdict_stage #(
    parameter int PIXEL_COUNT_BITS = ricv_pkg::PIXEL_COUNT_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  ricv_pkg::pixel_result_t           in_result,
    input  logic [ricv_pkg::SUM_W-1:0]        tot_sum,
    input  logic [ricv_pkg::CHAN_W-1:0]       tot_max,
    input  logic [PIXEL_COUNT_BITS-1:0]       tot_bad,
    input  logic [PIXEL_COUNT_BITS-1:0]       tot_count,
    input  ricv_pkg::cfg_t                    cfg,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ricv_pkg::CHAN_W-1:0]       diff_red,
    output logic [ricv_pkg::CHAN_W-1:0]       diff_green_blue,
    output logic                              verdict_valid,
    output logic                              pass_flag,
    output logic [ricv_pkg::CHAN_W-1:0]       max_channel_diff,
    output logic [ricv_pkg::OVER_W-1:0]       over_count,
    output logic [ricv_pkg::SUM_W-1:0]        diff_sum
);

    localparam int CW          = ricv_pkg::CHAN_W;
    localparam int SW          = ricv_pkg::SUM_W;
    localparam int OW          = ricv_pkg::OVER_W;
    localparam int MEAN_X3_W   = ricv_pkg::MEAN_TOL_W + 2;
    localparam int MEAN_PROD_W = MEAN_X3_W + PIXEL_COUNT_BITS;
    localparam int MEAN_LHS_W  = SW + ricv_pkg::MEAN_SCALE_SHIFT;
    localparam int MEAN_CMP_W  = (MEAN_LHS_W > MEAN_PROD_W) ? MEAN_LHS_W : MEAN_PROD_W;
    localparam int FRAC_PROD_W = ricv_pkg::FRAC_TOL_W + PIXEL_COUNT_BITS;
    localparam int OVER_CMP_W  = (PIXEL_COUNT_BITS > OW) ? PIXEL_COUNT_BITS : OW;

    // Product stage.
    logic                        mul_valid_reg;
    ricv_pkg::pixel_result_t     mul_result_reg;
    logic [SW-1:0]               mul_sum_reg;
    logic [CW-1:0]               mul_max_reg;
    logic [PIXEL_COUNT_BITS-1:0] mul_bad_reg;
    logic                        mul_ok_max_reg;
    logic [MEAN_PROD_W-1:0]      mul_mean_prod_reg, mul_mean_prod_next;
    logic [FRAC_PROD_W-1:0]      mul_frac_prod_reg, mul_frac_prod_next;
    logic [MEAN_X3_W-1:0]        mean_x3;

    // Result stage.
    logic                        res_valid_reg;
    logic [CW-1:0]               res_diff_red_reg;
    logic [CW-1:0]               res_diff_gb_reg;
    logic                        res_last_reg;
    logic                        res_pass_reg,  res_pass_next;
    logic [CW-1:0]               res_max_reg,   res_max_next;
    logic [OW-1:0]               res_over_reg,  res_over_next;
    logic [SW-1:0]               res_sum_reg,   res_sum_next;

    logic                        ok_mean, ok_frac;
    logic [OVER_CMP_W-1:0]       bad_wide;
    logic                        res_load, mul_load;

    assign res_load = !res_valid_reg || out_ready;
    assign mul_load = !mul_valid_reg || res_load;
    assign in_ready = mul_load;

    always_comb begin
        mean_x3 = MEAN_X3_W'(cfg.mean_tol_q8) + MEAN_X3_W'({cfg.mean_tol_q8, 1'b0});
        mul_mean_prod_next = MEAN_PROD_W'(mean_x3) * MEAN_PROD_W'(tot_count);
        mul_frac_prod_next = FRAC_PROD_W'(cfg.frac_tol_q16) * FRAC_PROD_W'(tot_count);
    end

    always_comb begin
        ok_mean = MEAN_CMP_W'({mul_sum_reg, {ricv_pkg::MEAN_SCALE_SHIFT{1'b0}}})
                  <= MEAN_CMP_W'(mul_mean_prod_reg);
        ok_frac = FRAC_PROD_W'({mul_bad_reg, {ricv_pkg::FRAC_SCALE_SHIFT{1'b0}}})
                  <= mul_frac_prod_reg;
        bad_wide = OVER_CMP_W'(mul_bad_reg);
        if (mul_result_reg.frame_end) begin
            res_pass_next = ok_mean && ok_frac && mul_ok_max_reg;
            res_max_next  = mul_max_reg;
            res_over_next = (bad_wide > OVER_CMP_W'({OW{1'b1}})) ? {OW{1'b1}}
                                                                 : bad_wide[OW-1:0];
            res_sum_next  = mul_sum_reg;
        end else begin
            res_pass_next = 1'b0;
            res_max_next  = '0;
            res_over_next = '0;
            res_sum_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (mul_load) begin
                mul_valid_reg <= in_valid;
            end
            if (res_load) begin
                res_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_load) begin
            mul_result_reg    <= in_result;
            mul_sum_reg       <= tot_sum;
            mul_max_reg       <= tot_max;
            mul_bad_reg       <= tot_bad;
            mul_ok_max_reg    <= tot_max <= cfg.max_tol;
            mul_mean_prod_reg <= mul_mean_prod_next;
            mul_frac_prod_reg <= mul_frac_prod_next;
        end
        if (res_load) begin
            res_diff_red_reg <= mul_result_reg.diff_red;
            res_diff_gb_reg  <= mul_result_reg.diff_green_blue;
            res_last_reg     <= mul_result_reg.frame_end;
            res_pass_reg     <= res_pass_next;
            res_max_reg      <= res_max_next;
            res_over_reg     <= res_over_next;
            res_sum_reg      <= res_sum_next;
        end
    end

    assign out_valid        = res_valid_reg;
    assign diff_red         = res_diff_red_reg;
    assign diff_green_blue  = res_diff_gb_reg;
    assign verdict_valid    = res_last_reg;
    assign pass_flag        = res_pass_reg;
    assign max_channel_diff = res_max_reg;
    assign over_count       = res_over_reg;
    assign diff_sum         = res_sum_reg;

endmodule

// ----- hdl/ricv_checker.sv -----
// Port-level assertions for the RGB image compare verdict block.
`include "assert_macros.svh"

module ricv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic [87:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast,
    input logic        m_tvalid,
    input logic        m_tready
);

    // Results that do not close a frame carry no totals and no verdict.
    `RICV_ASSERT(a_no_totals_midframe, aclk, aresetn, m_tvalid && !m_tlast |-> !m_tuser && m_tdata[87:16] == 72'd0, "totals shown on a result that does not close a frame")

    // Green and blue either follow red or are forced to zero.
    `RICV_ASSERT(a_green_blue_follows_red, aclk, aresetn, m_tvalid |-> m_tdata[15:8] == m_tdata[7:0] || m_tdata[15:8] == 8'd0, "green and blue neither follow red nor are zero")

    // A frame whose largest difference is zero has no bad pixels and no sum.
    `RICV_ASSERT(a_zero_max_zero_totals, aclk, aresetn, m_tvalid && m_tlast && m_tdata[23:16] == 8'd0 |-> m_tdata[87:24] == 64'd0, "zero largest difference with nonzero totals")

    // A stalled result holds.
    `RICV_ASSERT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // The result channel is empty after reset.
    `RICV_ASSERT_ALWAYS(a_empty_after_reset, aclk, !aresetn |=> !m_tvalid, "result valid right after reset")

endmodule

bind rgb_image_compare_verdict ricv_checker u_ricv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
